### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is held
`define RTE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rotary encoder check failed");

// clocked check that also runs during reset
`define RTE_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rotary encoder check failed");

`endif

### sv/rotenc_pkg.sv
// ----------------------------------------------------------------------------
// rotenc_pkg
// types and constants of the rotary encoder debounce block
// ----------------------------------------------------------------------------
`default_nettype none

package rotenc_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int STEP_WIDTH_DEF = 8;

    localparam int MODE_W    = 3;
    localparam int VALUE_IN_W = 16;
    localparam int VALUE_OUT_W = 15;
    localparam int TIME_OUT_W = 32;
    localparam int VALUE_TOP  = 32767;

    localparam logic [63:0] TIME_RESET = 64'h0000_0000_0FFF_FFFF;

    localparam int ROT_LOCK_W = 8;
    localparam int BTN_LOCK_W = 16;
    localparam logic [ROT_LOCK_W-1:0] ROT_LOCK_RST = 8'd1;
    localparam logic [BTN_LOCK_W-1:0] BTN_LOCK_RST = 16'd200;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK     = 3'd0,
        MODE_PHASE_A  = 3'd1,
        MODE_BUTTON   = 3'd2,
        MODE_ENC_POLL = 3'd3,
        MODE_BTN_POLL = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        REG_ROT_LOCKOUT = 2'd0,
        REG_BTN_LOCKOUT = 2'd1,
        REG_DIR_INVERT  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [ROT_LOCK_W-1:0] rot_lockout;
        logic [BTN_LOCK_W-1:0] btn_lockout;
        logic                  dir_invert;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_OUT_W-1:0] value_out;
        logic                   changed;
        logic                   button_pressed;
        logic [TIME_OUT_W-1:0]  time_ms;
    } t_result;

endpackage

`default_nettype wire

### sv/rotenc_in_if.sv
// ----------------------------------------------------------------------------
// rotenc_in_if
// input item channel: valid/ready plus event payload
// ----------------------------------------------------------------------------
`default_nettype none

interface rotenc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [rotenc_pkg::MODE_W-1:0]          mode;
    logic                                   phase_b_level;
    logic signed [rotenc_pkg::VALUE_IN_W-1:0] value_in;

    modport source (output valid, output mode, output phase_b_level, output value_in,
                    input ready);
    modport sink   (input valid, input mode, input phase_b_level, input value_in,
                    output ready);
endinterface

`default_nettype wire

### sv/rotenc_out_if.sv
// ----------------------------------------------------------------------------
// rotenc_out_if
// result item channel: valid/ready plus result payload
// ----------------------------------------------------------------------------
`default_nettype none

interface rotenc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [rotenc_pkg::VALUE_OUT_W-1:0]   value_out;
    logic                                 changed;
    logic                                 button_pressed;
    logic [rotenc_pkg::TIME_OUT_W-1:0]    time_ms;

    modport source (output valid, output value_out, output changed,
                    output button_pressed, output time_ms, input ready);
    modport sink   (input valid, input value_out, input changed,
                    input button_pressed, input time_ms, output ready);
endinterface

`default_nettype wire

### sv/rotenc_core.sv
// ----------------------------------------------------------------------------
// rotenc_core
// debounce state and per-event update, one event per fire strobe
// ----------------------------------------------------------------------------
`default_nettype none

module rotenc_core #(
    parameter int TIME_WIDTH = rotenc_pkg::TIME_WIDTH_DEF,
    parameter int STEP_WIDTH = rotenc_pkg::STEP_WIDTH_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire rotenc_pkg::t_cfg                          i_cfg,
    input  wire logic                                      i_fire,
    input  wire rotenc_pkg::t_mode                         i_mode,
    input  wire logic                                      i_phase_b_level,
    input  wire logic signed [rotenc_pkg::VALUE_IN_W-1:0]  i_value_in,
    output rotenc_pkg::t_result                            o_res
);

    localparam int ADJ_W = ((STEP_WIDTH > rotenc_pkg::VALUE_IN_W) ?
                            STEP_WIDTH : rotenc_pkg::VALUE_IN_W) + 2;
    localparam logic [TIME_WIDTH-1:0] TIME_RST = TIME_WIDTH'(rotenc_pkg::TIME_RESET);
    localparam logic [STEP_WIDTH-1:0] STEP_MAX = '1;
    localparam logic signed [ADJ_W-1:0] ADJ_TOP = ADJ_W'(rotenc_pkg::VALUE_TOP);

    logic [TIME_WIDTH-1:0] r_ms, n_ms;
    logic [TIME_WIDTH-1:0] r_last_rot, n_last_rot;
    logic [TIME_WIDTH-1:0] r_last_btn, n_last_btn;
    logic [STEP_WIDTH-1:0] r_steps, n_steps;
    logic                  r_dir, n_dir;
    logic                  r_press, n_press;

    logic                    rot_pass;
    logic                    btn_pass;
    logic signed [ADJ_W-1:0] v_ext;
    logic signed [ADJ_W-1:0] s_ext;
    logic signed [ADJ_W-1:0] v_adj;
    logic signed [ADJ_W-1:0] v_sel;
    logic                    apply;
    logic                    pressed;

    // lockout passes when the counter wrapped below the last time, or past the window
    assign rot_pass = (r_last_rot > r_ms) ||
                      ((r_ms - r_last_rot) > TIME_WIDTH'(i_cfg.rot_lockout));
    assign btn_pass = (r_last_btn > r_ms) ||
                      ((r_ms - r_last_btn) > TIME_WIDTH'(i_cfg.btn_lockout));

    assign v_ext = ADJ_W'(i_value_in);
    assign s_ext = $signed(ADJ_W'(r_steps));
    assign v_adj = r_dir ? (v_ext - s_ext) : (v_ext + s_ext);

    always_comb begin
        n_ms       = r_ms;
        n_last_rot = r_last_rot;
        n_last_btn = r_last_btn;
        n_steps    = r_steps;
        n_dir      = r_dir;
        n_press    = r_press;
        apply      = 1'b0;
        pressed    = 1'b0;
        unique case (i_mode)
            rotenc_pkg::MODE_TICK: begin
                n_ms = r_ms + 1'b1;
            end
            rotenc_pkg::MODE_PHASE_A: begin
                if (rot_pass) begin
                    n_last_rot = r_ms;
                    if (r_steps != STEP_MAX) begin
                        n_steps = r_steps + 1'b1;
                    end
                    n_dir = i_phase_b_level ^ i_cfg.dir_invert;
                end
            end
            rotenc_pkg::MODE_BUTTON: begin
                if (btn_pass) begin
                    n_last_btn = r_ms;
                    n_press    = 1'b1;
                end
            end
            rotenc_pkg::MODE_ENC_POLL: begin
                if (r_steps != '0) begin
                    apply   = 1'b1;
                    n_steps = '0;
                end
            end
            rotenc_pkg::MODE_BTN_POLL: begin
                pressed = r_press;
                n_press = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // floor at 0, saturate at the top
    assign v_sel = apply ? v_adj : v_ext;

    always_comb begin
        if (v_sel[ADJ_W-1]) begin
            o_res.value_out = '0;
        end else if (v_sel > ADJ_TOP) begin
            o_res.value_out = rotenc_pkg::VALUE_OUT_W'(rotenc_pkg::VALUE_TOP);
        end else begin
            o_res.value_out = v_sel[rotenc_pkg::VALUE_OUT_W-1:0];
        end
        o_res.changed        = apply;
        o_res.button_pressed = pressed;
        o_res.time_ms        = rotenc_pkg::TIME_OUT_W'(n_ms);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms       <= '0;
            r_last_rot <= TIME_RST;
            r_last_btn <= TIME_RST;
            r_steps    <= '0;
            r_dir      <= 1'b0;
            r_press    <= 1'b0;
        end else if (i_fire) begin
            r_ms       <= n_ms;
            r_last_rot <= n_last_rot;
            r_last_btn <= n_last_btn;
            r_steps    <= n_steps;
            r_dir      <= n_dir;
            r_press    <= n_press;
        end
    end

endmodule

`default_nettype wire

### sv/rotary_encoder_debounce_top.sv
// ----------------------------------------------------------------------------
// rotary_encoder_debounce_top
// rotary encoder and button debounce with millisecond time base
// ----------------------------------------------------------------------------
// Each input item is one event: a millisecond tick, a phase A falling edge,
// a button falling edge, an encoder poll or a button poll. Every item yields
// exactly one result item. The block takes one item per cycle while the sink
// keeps taking results: an item sits in the input register, the event logic
// (lockout compares, the step add and the value clamp) runs between that
// register and the result register, and the result is loaded into the result
// register when the item leaves the input register. The result register frees
// the input side as soon as the sink takes the waiting result, so with the
// sink always ready the sustained rate is one item per clock. Lockout and
// invert settings are written over the APB port at byte addresses 0, 4 and 8
// and should only change while no item is in flight.
`default_nettype none

module rotary_encoder_debounce_top #(
    parameter int TIME_WIDTH = rotenc_pkg::TIME_WIDTH_DEF,
    parameter int STEP_WIDTH = rotenc_pkg::STEP_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    rotenc_in_if.sink                              i_in,
    rotenc_out_if.source                           o_out,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rotenc_pkg::APB_AW-1:0]     paddr,
    input  wire logic [rotenc_pkg::APB_DW-1:0]     pwdata,
    output logic      [rotenc_pkg::APB_DW-1:0]     prdata,
    output logic                                   pready
);

    // configuration registers
    rotenc_pkg::t_cfg r_cfg;
    rotenc_pkg::t_reg_idx reg_idx;
    logic cfg_wr;

    // input register stage
    logic                                       r_s1_valid;
    rotenc_pkg::t_mode                          r_s1_mode;
    logic                                       r_s1_phase_b;
    logic signed [rotenc_pkg::VALUE_IN_W-1:0]   r_s1_value;

    // result register stage
    logic                r_out_valid;
    rotenc_pkg::t_result r_out;
    rotenc_pkg::t_result core_res;

    logic s1_adv;
    logic in_take;

    // ---------------------------------------------------------------- apb
    assign pready  = 1'b1;
    assign reg_idx = rotenc_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_lockout <= rotenc_pkg::ROT_LOCK_RST;
            r_cfg.btn_lockout <= rotenc_pkg::BTN_LOCK_RST;
            r_cfg.dir_invert  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                rotenc_pkg::REG_ROT_LOCKOUT:
                    r_cfg.rot_lockout <= pwdata[rotenc_pkg::ROT_LOCK_W-1:0];
                rotenc_pkg::REG_BTN_LOCKOUT:
                    r_cfg.btn_lockout <= pwdata[rotenc_pkg::BTN_LOCK_W-1:0];
                rotenc_pkg::REG_DIR_INVERT:
                    r_cfg.dir_invert  <= pwdata[0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    // read back, zero for unmapped addresses
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            rotenc_pkg::REG_ROT_LOCKOUT: prdata = rotenc_pkg::APB_DW'(r_cfg.rot_lockout);
            rotenc_pkg::REG_BTN_LOCKOUT: prdata = rotenc_pkg::APB_DW'(r_cfg.btn_lockout);
            rotenc_pkg::REG_DIR_INVERT:  prdata = rotenc_pkg::APB_DW'(r_cfg.dir_invert);
            default:                     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- flow
    // the stage-1 item moves on when the result register is empty or drains now
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_mode    <= rotenc_pkg::t_mode'(i_in.mode);
            r_s1_phase_b <= i_in.phase_b_level;
            r_s1_value   <= i_in.value_in;
        end
    end

    // ---------------------------------------------------------------- event logic
    // state advances exactly once per item, when it leaves stage 1
    rotenc_core #(
        .TIME_WIDTH (TIME_WIDTH),
        .STEP_WIDTH (STEP_WIDTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_fire          (s1_adv),
        .i_mode          (r_s1_mode),
        .i_phase_b_level (r_s1_phase_b),
        .i_value_in      (r_s1_value),
        .o_res           (core_res)
    );

    // ---------------------------------------------------------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= core_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.value_out      = r_out.value_out;
    assign o_out.changed        = r_out.changed;
    assign o_out.button_pressed = r_out.button_pressed;
    assign o_out.time_ms        = r_out.time_ms;

endmodule

`default_nettype wire

### sv/rotenc_checker.sv
// ----------------------------------------------------------------------------
// rotenc_checker
// port-level checks of the rotary encoder debounce block
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rotenc_checker (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   i_out_valid,
    input wire logic                                   i_out_ready,
    input wire logic [rotenc_pkg::VALUE_OUT_W-1:0]     i_value_out,
    input wire logic                                   i_changed,
    input wire logic                                   i_pressed,
    input wire logic [rotenc_pkg::TIME_OUT_W-1:0]      i_time_ms
);

    // a held result keeps its payload
    `RTE_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_value_out) && $stable(i_changed) && $stable(i_pressed) && $stable(i_time_ms)))

    // sync reset empties the result register
    `RTE_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid)

    // encoder poll and button poll results never coincide
    `RTE_ASSERT(a_flags_excl, i_clk, i_rst_n, i_out_valid |-> !(i_changed && i_pressed))

    // back-to-back results differ in time by at most one tick
    `RTE_ASSERT(a_time_order, i_clk, i_rst_n, (i_out_valid && i_out_ready && $past(i_out_valid && i_out_ready)) |-> ((i_time_ms == $past(i_time_ms)) || (i_time_ms == $past(i_time_ms) + 1'b1)))

endmodule

bind rotary_encoder_debounce_top rotenc_checker u_rotenc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_value_out (o_out.value_out),
    .i_changed   (o_out.changed),
    .i_pressed   (o_out.button_pressed),
    .i_time_ms   (o_out.time_ms)
);

`default_nettype wire
